// ===== rtl/core/bfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bump and first-fit allocator package
// Shared constants, register indexes and the stack cell operation type.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FREE_SLOTS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 48;
  localparam int SIZE_W         = 40;
  localparam int CHUNK_W        = 17;
  localparam int HDR_W          = 8;
  localparam int REQ_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 48;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_ROT   = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POP   = 2'd3
  } cell_op_t;

endpackage : bfa_pkg
`default_nettype wire

// ===== rtl/core/bump_and_first_fit_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bump and first-fit allocator
// A free passes through the push state and then raises out_valid. An allocate
// first spends the bit-serial chunk rounding, and a block carved from the bump
// tail is granted straight from the rounding state. When the tail does not fit,
// the free store makes one full rotation through its chain of cells past the
// top compare point before out_valid rises.
// Busy falls in the cycle that out_valid is high, so the next start can
// be accepted at the edge that ends it. Results appear for one cycle on
// out_valid and cannot be stalled.
// ----------------------------------------------------------------------------
module bump_and_first_fit_allocator_top
  import bfa_pkg::*;
#(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_mode,
  input  wire [REQ_W-1:0]      in_request_bytes,
  input  wire [ADDR_BITS-1:0]  in_user_addr,
  input  wire [SIZE_W-1:0]     in_block_bytes,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  output logic                 out_valid,
  output logic                 out_granted,
  output logic [ADDR_BITS-1:0] out_block_addr,
  output logic [ADDR_BITS-1:0] out_data_addr,
  output logic [SIZE_W-1:0]    out_granted_bytes,
  output logic                 out_dropped
);

  localparam int CNT_W = $clog2(FREE_SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FIX   = 6'b001000,
    S_PUSH  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r;
  logic [ADDR_BITS-1:0] heap_base_r, tail_addr_r;
  logic [SIZE_W-1:0]    heap_bytes_r, tail_left_r;
  logic [CHUNK_W-1:0]   chunk_r;
  logic [HDR_W-1:0]     hdr_r;
  logic                 tail_live_r;
  logic [CNT_W-1:0]     count_r, steps_r;
  logic                 hit_r;
  logic [ADDR_BITS-1:0] ua_r;
  logic [SIZE_W-1:0]    bb_r;

  logic [ADDR_BITS-1:0] cell_addr [FREE_SLOTS];
  logic [SIZE_W-1:0]    cell_bytes[FREE_SLOTS];
  cell_op_t             cell_op;
  logic [ADDR_BITS-1:0] top_addr_in;
  logic [SIZE_W-1:0]    top_bytes_in;

  logic                 rnd_go, rnd_done;
  logic [SIZE_W-1:0]    sz;
  logic [CHUNK_W-1:0]   g1;
  logic [ADDR_BITS-1:0] bot_addr;
  logic [SIZE_W-1:0]    bot_bytes;
  logic [SIZE_W-1:0]    sz_r;

  assign g1 = (chunk_r == '0) ? CHUNK_W'(1) : chunk_r;

  // Cell 0 is the top of the store; rotation moves entries up toward it from
  // the bottom of the live region, with the top entry reinserted at the end.
  assign bot_addr  = cell_addr[0];
  assign bot_bytes = cell_bytes[0];

  bfa_round u_round (
    .clk(clk), .rst_n(rst_n), .go(rnd_go),
    .n({1'b0, in_request_bytes} + (REQ_W+1)'(hdr_r)),
    .g(chunk_r), .done_r(rnd_done), .sz_r(sz)
  );

  genvar gi;
  generate
    for (gi = 0; gi < FREE_SLOTS; gi++) begin : g_cell
      logic [ADDR_BITS-1:0] ua, da;
      logic [SIZE_W-1:0]    ub, db;
      cell_op_t             op_i;
      if (gi == FREE_SLOTS - 1) begin : g_last
        assign ua = top_addr_in;
        assign ub = top_bytes_in;
      end else begin : g_mid
        assign ua = (CNT_W'(gi) == count_r - 1'b1) ? top_addr_in : cell_addr[gi+1];
        assign ub = (CNT_W'(gi) == count_r - 1'b1) ? top_bytes_in : cell_bytes[gi+1];
      end
      if (gi == 0) begin : g_first
        assign da = top_addr_in;
        assign db = top_bytes_in;
      end else begin : g_lo
        assign da = cell_addr[gi-1];
        assign db = cell_bytes[gi-1];
      end
      // In a rotation, the cell at the live end takes the returning entry.
      always_comb begin
        op_i = cell_op;
        if (cell_op == OP_POP && CNT_W'(gi) == count_r - 1'b1) op_i = OP_HOLD;
        if (CNT_W'(gi) >= count_r && cell_op != OP_PUSH) op_i = OP_HOLD;
      end
      bfa_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk(clk), .op(op_i),
        .up_addr(ua), .up_bytes(ub),
        .dn_addr(gi == 0 ? top_addr_in : da),
        .dn_bytes(gi == 0 ? top_bytes_in : db),
        .addr_r(cell_addr[gi]), .bytes_r(cell_bytes[gi])
      );
    end
  endgenerate

  // Rotation: cell 0 holds the newest entry. Each ROT shifts cells down by
  // one (cell k takes cell k+1) and the old cell 0 re-enters at count-1.
  // That makes cell 0 walk newest to oldest.
  logic       fit, split;
  logic [SIZE_W-1:0] rest;
  assign fit   = sz_r <= bot_bytes;
  assign rest  = bot_bytes - sz_r;
  assign split = rest >= SIZE_W'(g1);

  always_comb begin
    cell_op      = OP_HOLD;
    top_addr_in  = bot_addr;
    top_bytes_in = bot_bytes;
    rnd_go       = 1'b0;
    if (state_r == S_IDLE && start && !in_mode) rnd_go = 1'b1;
    if (state_r == S_SCAN && steps_r != '0) begin
      if (!hit_r && fit) begin
        if (split) begin
          cell_op      = OP_ROT;
          top_addr_in  = bot_addr + ADDR_BITS'(sz_r);
          top_bytes_in = rest;
        end else begin
          cell_op = OP_POP;
        end
      end else begin
        cell_op = OP_ROT;
      end
    end
    if (state_r == S_PUSH && count_r < CNT_W'(FREE_SLOTS)) begin
      cell_op      = OP_PUSH;
      top_addr_in  = ua_r - ADDR_BITS'(hdr_r);
      top_bytes_in = bb_r;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_base_r  <= '0;
      heap_bytes_r <= SIZE_W'(1073741824);
      chunk_r      <= CHUNK_W'(64);
      hdr_r        <= HDR_W'(24);
      tail_addr_r  <= '0;
      tail_left_r  <= SIZE_W'(1073741824);
      tail_live_r  <= 1'b1;
      count_r      <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HEAP_BASE: begin
            heap_base_r <= ADDR_BITS'(cfg_data);
            tail_addr_r <= ADDR_BITS'(cfg_data);
            tail_left_r <= heap_bytes_r;
            tail_live_r <= 1'b1;
          end
          REG_HEAP_BYTES: begin
            heap_bytes_r <= cfg_data[SIZE_W-1:0];
            tail_addr_r  <= heap_base_r;
            tail_left_r  <= cfg_data[SIZE_W-1:0];
            tail_live_r  <= 1'b1;
          end
          REG_CHUNK:  chunk_r <= cfg_data[CHUNK_W-1:0];
          REG_HEADER: hdr_r   <= cfg_data[HDR_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          ua_r               <= in_user_addr;
          bb_r               <= in_block_bytes;
          state_r            <= in_mode ? S_PUSH : S_ROUND;
        end
        S_ROUND: if (rnd_done) begin
          sz_r  <= sz;
          hit_r <= 1'b0;
          if (tail_live_r && sz <= tail_left_r) begin
            out_granted       <= 1'b1;
            out_block_addr    <= tail_addr_r;
            out_data_addr     <= tail_addr_r + ADDR_BITS'(hdr_r);
            out_granted_bytes <= sz;
            out_dropped       <= 1'b0;
            tail_addr_r       <= tail_addr_r + ADDR_BITS'(sz);
            tail_left_r       <= tail_left_r - sz;
            if (tail_left_r == sz) tail_live_r <= 1'b0;
            out_valid         <= 1'b1;
            state_r           <= S_IDLE;
          end else begin
            steps_r <= count_r;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (steps_r == '0) begin
            if (!hit_r) begin
              out_granted       <= 1'b0;
              out_block_addr    <= '0;
              out_data_addr     <= '0;
              out_granted_bytes <= '0;
              out_dropped       <= 1'b0;
            end
            state_r <= S_FIX;
          end else begin
            steps_r <= steps_r - 1'b1;
            if (!hit_r && fit) begin
              hit_r             <= 1'b1;
              out_granted       <= 1'b1;
              out_block_addr    <= bot_addr;
              out_data_addr     <= bot_addr + ADDR_BITS'(hdr_r);
              out_granted_bytes <= sz_r;
              out_dropped       <= 1'b0;
              if (!split) begin
                count_r <= count_r - 1'b1;
              end
            end
          end
        end
        S_FIX: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_PUSH: begin
          out_block_addr    <= ua_r - ADDR_BITS'(hdr_r);
          out_data_addr     <= ua_r;
          out_granted_bytes <= bb_r;
          if (count_r < CNT_W'(FREE_SLOTS)) begin
            count_r     <= count_r + 1'b1;
            out_granted <= 1'b1;
            out_dropped <= 1'b0;
          end else begin
            out_granted <= 1'b0;
            out_dropped <= 1'b1;
          end
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FREE_SLOTS)) else $error("free store count overflow");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && out_dropped)) else $error("grant and drop");
`endif

endmodule : bump_and_first_fit_allocator_top
`default_nettype wire

// ===== rtl/core/bfa_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Free store cell
// Holds one extent and passes it to its neighbor on rotate, push and pop.
// ----------------------------------------------------------------------------
module bfa_cell
  import bfa_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire                 clk,
  input  cell_op_t            op,
  input  wire [ADDR_BITS-1:0] up_addr,
  input  wire [SIZE_W-1:0]    up_bytes,
  input  wire [ADDR_BITS-1:0] dn_addr,
  input  wire [SIZE_W-1:0]    dn_bytes,
  output logic [ADDR_BITS-1:0] addr_r,
  output logic [SIZE_W-1:0]    bytes_r
);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: begin
      end
      OP_ROT, OP_POP: begin
        addr_r  <= up_addr;
        bytes_r <= up_bytes;
      end
      OP_PUSH: begin
        addr_r  <= dn_addr;
        bytes_r <= dn_bytes;
      end
      default: begin
      end
    endcase
  end

endmodule : bfa_cell
`default_nettype wire

// ===== rtl/core/bfa_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk rounding unit
// Rounds a size up to a multiple of the chunk by restoring division.
// ----------------------------------------------------------------------------
module bfa_round
  import bfa_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 go,
  input  wire [REQ_W:0]       n,
  input  wire [CHUNK_W-1:0]   g,
  output logic                done_r,
  output logic [SIZE_W-1:0]   sz_r
);

  localparam int NW = REQ_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    n_r;
  logic [NW-1:0]    q_r;
  logic [CHUNK_W:0] rem_r;
  logic [CHUNK_W-1:0] g_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic [CHUNK_W:0] sh;

  assign sh = {rem_r[CHUNK_W-1:0], q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
        q_r   <= n;
        n_r   <= n;
        rem_r <= '0;
        g_r   <= (g == '0) ? CHUNK_W'(1) : g;
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          sz_r   <= (rem_r == '0) ? SIZE_W'(n_r)
                  : SIZE_W'(n_r) + SIZE_W'(g_r) - SIZE_W'(rem_r);
        end else begin
          cnt_r <= cnt_r - 1'b1;
          if (sh >= {1'b0, g_r}) begin
            rem_r <= sh - {1'b0, g_r};
            q_r   <= {q_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= sh;
            q_r   <= {q_r[NW-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule : bfa_round
`default_nettype wire
